// ----- design/csrq_pkg.sv -----
// Shared types and constants for the CSR edge membership query block.
// Field widths, request codes, default table sizes and the search step status.
// No dependencies.
package csrq_pkg;

   // fixed field widths
   localparam int FUNC_W   = 2;
   localparam int ADDR_W   = 13;
   localparam int VALUE_W  = 14;
   localparam int VERTEX_W = 10;
   localparam int COUNT_W  = 11;

   // packed request layout: tdata = {vertex_b, vertex_a, entry_value, entry_address}
   localparam int REQ_ADDR_LSB  = 0;
   localparam int REQ_VALUE_LSB = REQ_ADDR_LSB + ADDR_W;
   localparam int REQ_VA_LSB    = REQ_VALUE_LSB + VALUE_W;
   localparam int REQ_VB_LSB    = REQ_VA_LSB + VERTEX_W;
   localparam int REQ_BITS      = REQ_VB_LSB + VERTEX_W;
   localparam int REQ_DATA_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W    = 8;

   // default table sizes
   localparam int MAX_VERTICES_DEF  = 1024;
   localparam int MAX_ADJACENCY_DEF = 8192;

   // request kinds
   localparam logic [FUNC_W-1:0] FUNC_WR_OFFSET = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WR_ADJ    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY     = 2'd2;

   // status of one binary-search step
   typedef struct packed {
      logic hit;   // probed entry equals the key
      logic more;  // range still non-empty, next probe wanted
   } step_status_type;

endpackage

// ----- design/csrq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the offset table and the adjacency table. No dependencies.
module csrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/csrq_alu.sv -----
// Shared binary-search step unit: compares the probed neighbor with the key,
// narrows the range and forms the next midpoint. Depends on csrq_pkg.
module csrq_alu #(
   parameter int BW = 14
) (
   input  logic                             do_cmp,
   input  logic [BW-1:0]                    lo,
   input  logic [BW-1:0]                    hi,
   input  logic [BW-1:0]                    mid,
   input  logic [csrq_pkg::VERTEX_W-1:0]    key,
   input  logic [csrq_pkg::VERTEX_W-1:0]    probe,
   output logic [BW-1:0]                    next_lo,
   output logic [BW-1:0]                    next_hi,
   output logic [BW-1:0]                    next_mid,
   output csrq_pkg::step_status_type        status
);

   logic [BW:0] mid_sum;

   always_comb begin
      next_lo = lo;
      next_hi = hi;
      if (do_cmp) begin
         if (key < probe) begin
            next_hi = mid;
         end else begin
            next_lo = mid + BW'(1);
         end
      end
      mid_sum       = {1'b0, next_lo} + {1'b0, next_hi};
      next_mid      = mid_sum[BW:1];
      status.hit    = do_cmp && (probe == key);
      status.more   = !status.hit && (next_lo < next_hi);
   end

endmodule

// ----- design/csr_edge_membership_query.sv -----
// Edge membership query on a CSR graph: offset and adjacency RAMs, query sequencer.
// A query reads four offsets (one per cycle), then probes the adjacency RAM once per cycle;
// at most log2(list length) + 1 probes are made. A bad endpoint is answered from the idle
// state without offset reads. Table writes are taken one per cycle while the block is idle
// and holds no result; after a query, req_tready stays low until its result transfers.
// Sync reset clears sequencer, result valid, vertex_count; tables undefined until written.
module csr_edge_membership_query #(
   parameter int MAX_VERTICES  = csrq_pkg::MAX_VERTICES_DEF,
   parameter int MAX_ADJACENCY = csrq_pkg::MAX_ADJACENCY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: entry_address, entry_value, vertex_a, vertex_b (from bit 0 up)
   input  logic [csrq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: func
   input  logic [csrq_pkg::FUNC_W-1:0]       req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: edge_present
   output logic [csrq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: bad_vertex
   output logic                              rsp_tuser,
   // vertex_count register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [csrq_pkg::COUNT_W-1:0]      csr_data
);

   localparam int OFF_DEPTH = MAX_VERTICES + 1;
   localparam int OFF_AW    = $clog2(OFF_DEPTH);
   localparam int ADJ_AW    = (MAX_ADJACENCY > 1) ? $clog2(MAX_ADJACENCY) : 1;
   localparam int BW        = $clog2(MAX_ADJACENCY + 1);
   localparam int VW        = csrq_pkg::VERTEX_W;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RA1   = 7'b0000010,
      S_RB0   = 7'b0000100,
      S_RB1   = 7'b0001000,
      S_SEL   = 7'b0010000,
      S_PROBE = 7'b0100000,
      S_CMP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [csrq_pkg::COUNT_W-1:0] vcount_ff;

   logic [VW-1:0] a_ff, a_in, b_ff, b_in, key_ff, key_in;
   logic [BW-1:0] beg_a_ff, beg_a_in, end_a_ff, end_a_in, beg_b_ff, beg_b_in;
   logic [BW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_edge_ff, rsp_edge_in;
   logic          rsp_bad_ff, rsp_bad_in;

   // request fields
   logic [csrq_pkg::ADDR_W-1:0]  req_addr;
   logic [csrq_pkg::VALUE_W-1:0] req_value;
   logic [VW-1:0]                req_a, req_b;
   logic                         req_xfer, bad_ends;

   logic [31:0] wr_addr_ext;
   logic        off_we, adj_we;
   logic [OFF_AW-1:0] off_raddr;
   logic [ADJ_AW-1:0] adj_raddr;
   logic [csrq_pkg::VALUE_W-1:0] off_rdata;
   logic [VW-1:0]                adj_rdata;

   logic [BW-1:0] sat_val, end_b, len_a, len_b;
   logic [BW-1:0] nxt_lo, nxt_hi, nxt_mid;
   csrq_pkg::step_status_type step_st;

   function automatic logic [OFF_AW-1:0] vidx(input logic [VW-1:0] v, input logic inc);
      logic [31:0] t;
      t = 32'(v) + 32'(inc);
      return t[OFF_AW-1:0];
   endfunction

   function automatic logic [BW-1:0] sat_bound(input logic [csrq_pkg::VALUE_W-1:0] d);
      logic [31:0] x;
      x = 32'(d);
      if (x > 32'(MAX_ADJACENCY)) begin
         x = 32'(MAX_ADJACENCY);
      end
      return x[BW-1:0];
   endfunction

   assign req_addr  = req_tdata[csrq_pkg::REQ_ADDR_LSB  +: csrq_pkg::ADDR_W];
   assign req_value = req_tdata[csrq_pkg::REQ_VALUE_LSB +: csrq_pkg::VALUE_W];
   assign req_a     = req_tdata[csrq_pkg::REQ_VA_LSB    +: VW];
   assign req_b     = req_tdata[csrq_pkg::REQ_VB_LSB    +: VW];

   // no transfer is taken on either channel while reset is high
   assign req_tready = !reset && (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   assign bad_ends = ({1'b0, req_a} >= vcount_ff) || ({1'b0, req_b} >= vcount_ff) ||
                     (32'(req_a) >= 32'(MAX_VERTICES)) || (32'(req_b) >= 32'(MAX_VERTICES));

   // table writes, out-of-range addresses dropped
   assign wr_addr_ext = 32'(req_addr);
   assign off_we = req_xfer && (req_tuser == csrq_pkg::FUNC_WR_OFFSET) &&
                   (wr_addr_ext < 32'(OFF_DEPTH));
   assign adj_we = req_xfer && (req_tuser == csrq_pkg::FUNC_WR_ADJ) &&
                   (wr_addr_ext < 32'(MAX_ADJACENCY));

   csrq_ram #(
      .WIDTH (csrq_pkg::VALUE_W),
      .DEPTH (OFF_DEPTH)
   ) u_off_ram (
      .clock   (clock),
      .wr_en   (off_we),
      .wr_addr (wr_addr_ext[OFF_AW-1:0]),
      .wr_data (req_value),
      .rd_addr (off_raddr),
      .rd_data (off_rdata)
   );

   csrq_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_ADJACENCY)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (wr_addr_ext[ADJ_AW-1:0]),
      .wr_data (req_value[VW-1:0]),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   csrq_alu #(
      .BW (BW)
   ) u_alu (
      .do_cmp   (state_ff == S_CMP),
      .lo       (lo_ff),
      .hi       (hi_ff),
      .mid      (mid_ff),
      .key      (key_ff),
      .probe    (adj_rdata),
      .next_lo  (nxt_lo),
      .next_hi  (nxt_hi),
      .next_mid (nxt_mid),
      .status   (step_st)
   );

   assign adj_raddr = nxt_mid[ADJ_AW-1:0];

   // list bounds of the vertex currently being read; empty when end lies below start
   assign sat_val = sat_bound(off_rdata);
   assign end_b   = (sat_val < beg_b_ff) ? beg_b_ff : sat_val;
   assign len_a   = end_a_ff - beg_a_ff;
   assign len_b   = end_b - beg_b_ff;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      key_in       = key_ff;
      beg_a_in     = beg_a_ff;
      end_a_in     = end_a_ff;
      beg_b_in     = beg_b_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_edge_in  = rsp_edge_ff;
      rsp_bad_in   = rsp_bad_ff;
      off_raddr    = vidx(req_a, 1'b0);

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_tuser == csrq_pkg::FUNC_QUERY)) begin
               a_in = req_a;
               b_in = req_b;
               if (bad_ends) begin
                  rsp_valid_in = 1'b1;
                  rsp_edge_in  = 1'b0;
                  rsp_bad_in   = 1'b1;
               end else begin
                  state_in = S_RA1;
               end
            end
         end
         S_RA1: begin
            off_raddr = vidx(a_ff, 1'b1);
            beg_a_in  = sat_val;
            state_in  = S_RB0;
         end
         S_RB0: begin
            off_raddr = vidx(b_ff, 1'b0);
            end_a_in  = (sat_val < beg_a_ff) ? beg_a_ff : sat_val;
            state_in  = S_RB1;
         end
         S_RB1: begin
            off_raddr = vidx(b_ff, 1'b1);
            beg_b_in  = sat_val;
            state_in  = S_SEL;
         end
         S_SEL: begin
            // search the shorter list, vertex_a's on a tie
            if (len_a <= len_b) begin
               lo_in  = beg_a_ff;
               hi_in  = end_a_ff;
               key_in = b_ff;
            end else begin
               lo_in  = beg_b_ff;
               hi_in  = end_b;
               key_in = a_ff;
            end
            state_in = S_PROBE;
         end
         S_PROBE, S_CMP: begin
            if (step_st.hit || !step_st.more) begin
               rsp_valid_in = 1'b1;
               rsp_edge_in  = step_st.hit;
               rsp_bad_in   = 1'b0;
               state_in     = S_IDLE;
            end else begin
               lo_in    = nxt_lo;
               hi_in    = nxt_hi;
               mid_in   = nxt_mid;
               state_in = S_CMP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      key_ff      <= key_in;
      beg_a_ff    <= beg_a_in;
      end_a_ff    <= end_a_in;
      beg_b_ff    <= beg_b_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      rsp_edge_ff <= rsp_edge_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(csrq_pkg::RSP_DATA_W-1){1'b0}}, rsp_edge_ff};
   assign rsp_tuser  = rsp_bad_ff;

`ifndef ASSERT_OFF
   // a probe is only in flight on a non-empty range with mid inside it
   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (lo_ff <= mid_ff) && (mid_ff < hi_ff))
      else $error("search probe outside current range");

   // a result appears only from an accepted query or the end of a search
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ($past(state_ff) == S_PROBE) || ($past(state_ff) == S_CMP) ||
         (($past(state_ff) == S_IDLE) && $past(req_xfer)))
      else $error("result raised without a query");

   // bad endpoint never reports an edge
   a_bad_no_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> !rsp_edge_ff)
      else $error("bad vertex result claims an edge");

   // an accepted query with valid endpoints moves to the first offset read and drops req_tready
   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_tuser == csrq_pkg::FUNC_QUERY) && !bad_ends) |=>
         !req_tready && (state_ff == S_RA1))
      else $error("query did not start offset reads");
`endif

endmodule

// ----- dv/tb_csr_edge_membership_query.sv -----
`timescale 1ns / 100ps
// Testbench for csr_edge_membership_query: loads CSR graphs, runs edge queries and
// checks every result against an in-bench mirror of the offset and adjacency tables.
// Depends on csrq_pkg and the csr_edge_membership_query RTL.
module tb_csr_edge_membership_query;

   localparam logic [csrq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int OFFSET_DEPTH = csrq_pkg::MAX_VERTICES_DEF + 1;
   localparam int ADJ_DEPTH    = csrq_pkg::MAX_ADJACENCY_DEF;
   localparam int SETTLE       = 32;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LOAD_CAP     = 16;
   localparam int QUERY_ITEMS  = 100;

   typedef struct packed {
      logic edge_present;
      logic bad_vertex;
   } edge_answer_type;

   // Mirror of the graph tables plus the queue of answers still owed by the block.
   class edge_query_board_type;
      logic [csrq_pkg::VALUE_W-1:0]  offs [0:OFFSET_DEPTH-1];
      logic [csrq_pkg::VERTEX_W-1:0] nbrs [0:ADJ_DEPTH-1];
      bit                            off_set [0:OFFSET_DEPTH-1];
      bit                            nbr_set [0:ADJ_DEPTH-1];
      logic [csrq_pkg::COUNT_W-1:0]  vcount;
      edge_answer_type               answers [$];
      int                            mismatches;

      function new();
         vcount = '0;
         mismatches = 0;
      endfunction

      // half-open neighbor range of v, saturated, empty when reversed
      function void list_range(int v, output int lo, output int hi);
         lo = offs[v];
         hi = offs[v+1];
         if (lo > ADJ_DEPTH) lo = ADJ_DEPTH;
         if (hi > ADJ_DEPTH) hi = ADJ_DEPTH;
         if (hi < lo) hi = lo;
      endfunction

      function bit list_has(int lo, int hi, logic [csrq_pkg::VERTEX_W-1:0] key);
         int mid;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (nbrs[mid] == key) return 1'b1;
            if (key < nbrs[mid]) hi = mid;
            else lo = mid + 1;
         end
         return 1'b0;
      endfunction

      // true when the query touches only entries loaded since reset
      function bit query_safe(int a, int b);
         int alo, ahi, blo, bhi, lo, hi;
         if (a >= vcount || b >= vcount) return 1'b1;
         if (!(off_set[a] && off_set[a+1] && off_set[b] && off_set[b+1])) return 1'b0;
         list_range(a, alo, ahi);
         list_range(b, blo, bhi);
         if (ahi - alo <= bhi - blo) begin
            lo = alo;
            hi = ahi;
         end else begin
            lo = blo;
            hi = bhi;
         end
         for (int i = lo; i < hi; i++)
            if (!nbr_set[i]) return 1'b0;
         return 1'b1;
      endfunction

      function void note_request(logic [csrq_pkg::FUNC_W-1:0] f,
                                 logic [csrq_pkg::ADDR_W-1:0] addr,
                                 logic [csrq_pkg::VALUE_W-1:0] val,
                                 logic [csrq_pkg::VERTEX_W-1:0] va,
                                 logic [csrq_pkg::VERTEX_W-1:0] vb);
         edge_answer_type ans;
         int alo, ahi, blo, bhi;
         case (f)
            csrq_pkg::FUNC_WR_OFFSET: begin
               if (addr < OFFSET_DEPTH) begin
                  offs[addr] = val;
                  off_set[addr] = 1'b1;
               end
            end
            csrq_pkg::FUNC_WR_ADJ: begin
               if (addr < ADJ_DEPTH) begin
                  nbrs[addr] = val[csrq_pkg::VERTEX_W-1:0];
                  nbr_set[addr] = 1'b1;
               end
            end
            csrq_pkg::FUNC_QUERY: begin
               if (va >= vcount || vb >= vcount) begin
                  ans.edge_present = 1'b0;
                  ans.bad_vertex = 1'b1;
               end else begin
                  list_range(va, alo, ahi);
                  list_range(vb, blo, bhi);
                  // shorter list is searched, list of vertex_a on a tie
                  if (ahi - alo <= bhi - blo) ans.edge_present = list_has(alo, ahi, vb);
                  else ans.edge_present = list_has(blo, bhi, va);
                  ans.bad_vertex = 1'b0;
               end
               answers.push_back(ans);
            end
            default: ;
         endcase
      endfunction

      function void check_answer(logic edge_present, logic bad_vertex);
         edge_answer_type want;
         if (answers.size() == 0) begin
            $error("result transfer with no query outstanding: edge_present=%0b bad_vertex=%0b",
                   edge_present, bad_vertex);
            mismatches++;
            return;
         end
         want = answers.pop_front();
         if (edge_present !== want.edge_present) begin
            $error("edge_present: expected %0b, actual %0b", want.edge_present, edge_present);
            mismatches++;
         end
         if (bad_vertex !== want.bad_vertex) begin
            $error("bad_vertex: expected %0b, actual %0b", want.bad_vertex, bad_vertex);
            mismatches++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [csrq_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [csrq_pkg::FUNC_W-1:0]     req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [csrq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [csrq_pkg::COUNT_W-1:0]    csr_data = '0;

   edge_query_board_type sb;
   int snd_idle = 37;
   int rcv_idle = 67;
   int cycles = 0;

   csr_edge_membership_query dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: check transfers, then pick next cycle's ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_answer(rsp_tdata[0], rsp_tuser);
         rsp_tready <= ($urandom_range(0, 99) >= rcv_idle);
      end
   end

   task automatic send_req(input logic [csrq_pkg::FUNC_W-1:0] f, input int addr,
                           input int val, input int va, input int vb);
      logic [csrq_pkg::REQ_DATA_W-1:0] d;
      d = '0;
      d[csrq_pkg::REQ_ADDR_LSB +: csrq_pkg::ADDR_W]    = addr[csrq_pkg::ADDR_W-1:0];
      d[csrq_pkg::REQ_VALUE_LSB +: csrq_pkg::VALUE_W]  = val[csrq_pkg::VALUE_W-1:0];
      d[csrq_pkg::REQ_VA_LSB +: csrq_pkg::VERTEX_W]    = va[csrq_pkg::VERTEX_W-1:0];
      d[csrq_pkg::REQ_VB_LSB +: csrq_pkg::VERTEX_W]    = vb[csrq_pkg::VERTEX_W-1:0];
      while ($urandom_range(0, 99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= f;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_request(f, addr[csrq_pkg::ADDR_W-1:0], val[csrq_pkg::VALUE_W-1:0],
                      va[csrq_pkg::VERTEX_W-1:0], vb[csrq_pkg::VERTEX_W-1:0]);
   endtask

   task automatic query(input int a, input int b);
      send_req(csrq_pkg::FUNC_QUERY, $urandom_range(0, 8191), $urandom_range(0, 16383), a, b);
   endtask

   task automatic wr_off(input int addr, input int val);
      send_req(csrq_pkg::FUNC_WR_OFFSET, addr, val, $urandom_range(0, 1023),
               $urandom_range(0, 1023));
   endtask

   task automatic wr_adj(input int addr, input int val);
      send_req(csrq_pkg::FUNC_WR_ADJ, addr, val, $urandom_range(0, 1023),
               $urandom_range(0, 1023));
   endtask

   // wait until every answer is in and the block has had time to go idle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_count(input int v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v[csrq_pkg::COUNT_W-1:0];
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      sb.vcount = v[csrq_pkg::COUNT_W-1:0];
   endtask

   // random graph over vertices 0..nv-1, lists sorted on the stored low bits
   task automatic load_graph(input int nv);
      int pos, deg, val;
      int nbr [$];
      pos = $urandom_range(0, (nv > 256) ? 3000 : 7000);
      for (int v = 0; v < nv; v++) begin
         wr_off(v, pos);
         if (nv > 256)
            deg = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0;
         else
            deg = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 10);
         if (pos + deg > ADJ_DEPTH) deg = ADJ_DEPTH - pos;
         nbr.delete();
         repeat (deg) nbr.push_back($urandom_range(0, nv - 1));
         nbr.sort();
         foreach (nbr[i]) begin
            val = nbr[i];
            if ($urandom_range(0, 9) == 0) val += $urandom_range(1, 15) << csrq_pkg::VERTEX_W;
            wr_adj(pos, val);
            pos++;
         end
      end
      wr_off(nv, pos);
   endtask

   // valid-vertex queries stay inside the loaded vertices 0..n_loaded-1
   task automatic run_queries(input int n_items, input int count, input int n_loaded);
      int nv, r, a, b, lo, hi, k;
      bit ok;
      nv = n_loaded;
      repeat (n_items) begin
         r = $urandom_range(0, 99);
         if (r < 72 && nv > 0) begin
            ok = 1'b0;
            for (int t = 0; t < 8 && !ok; t++) begin
               a = $urandom_range(0, nv - 1);
               b = $urandom_range(0, nv - 1);
               // half the time aim at a real neighbor of a
               if ($urandom_range(0, 1) == 1 && sb.off_set[a] && sb.off_set[a+1]) begin
                  sb.list_range(a, lo, hi);
                  if (hi > lo) begin
                     k = $urandom_range(lo, hi - 1);
                     if (sb.nbr_set[k] && sb.nbrs[k] < nv) b = sb.nbrs[k];
                  end
               end
               ok = sb.query_safe(a, b);
            end
            if (ok) query(a, b);
         end else if (r < 86 && count < csrq_pkg::MAX_VERTICES_DEF) begin
            a = $urandom_range(0, 1023);
            b = $urandom_range(0, 1023);
            case ($urandom_range(0, 2))
               0: a = $urandom_range(count, 1023);
               1: b = $urandom_range(count, 1023);
               default: begin
                  a = $urandom_range(count, 1023);
                  b = $urandom_range(count, 1023);
               end
            endcase
            query(a, b);
         end else if (r < 90) begin
            send_req(FUNC_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 16383),
                     $urandom_range(0, 1023), $urandom_range(0, 1023));
         end else if (r < 95) begin
            wr_adj($urandom_range(0, ADJ_DEPTH - 1), $urandom_range(0, 16383));
         end else if (r < 98) begin
            wr_off($urandom_range(0, nv), $urandom_range(0, 16383));
         end else begin
            wr_off($urandom_range(OFFSET_DEPTH, 8191), $urandom_range(0, 16383));
         end
      end
   endtask

   initial begin
      int count, n_load;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no vertices: every query flagged, ignored codes and addresses
      write_count(0);
      query(0, 0);
      query(1023, 1023);
      send_req(FUNC_UNUSED, 8191, 16383, 1023, 1023);
      wr_off(8191, 16383);
      wr_off(OFFSET_DEPTH, 0);

      // vertex 0: {1,3,5} (5 stored from a wide value), vertex 1: {0},
      // vertex 1022: reversed bounds past the table end, vertex 1023: bounds saturated
      wr_off(0, 0);
      wr_off(1, 3);
      wr_off(2, 4);
      wr_adj(0, 1);
      wr_adj(1, 3);
      wr_adj(2, 16'h3C05);
      wr_adj(3, 0);
      wr_off(1022, 9000);
      wr_off(1023, 8190);
      wr_off(1024, 16383);
      wr_adj(8190, 0);
      wr_adj(8191, 16383);

      write_count(1024);
      query(0, 1);
      query(1, 0);
      query(0, 0);
      query(1023, 0);
      query(1023, 1023);
      query(1022, 0);
      query(1022, 1023);
      write_count(2047);
      query(1023, 1);
      query(0, 1023);
      write_count(1);
      query(0, 1);
      query(0, 0);
      query(1023, 0);

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin
               snd_idle = 37;
               rcv_idle = 67;
            end
            1: begin
               snd_idle = 67;
               rcv_idle = 37;
            end
            default: begin
               snd_idle = 0;
               rcv_idle = 0;
            end
         endcase
         case (p)
            0: count = $urandom_range(2, 24);
            1: count = 1024;
            2: count = $urandom_range(40, 100);
            3: count = 2047;
            4: count = 1;
            default: count = $urandom_range(2, 12);
         endcase
         write_count(count);
         n_load = (count < LOAD_CAP) ? count : LOAD_CAP;
         load_graph(n_load);
         run_queries(QUERY_ITEMS, count, n_load);
      end

      drain();
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
